// File: rtl/id3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3_pkg
// Types and codes shared by the ID3v2 tag stream parser.
// ----------------------------------------------------------------------------
package id3_pkg;

  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_3    = 8'h33;
  localparam logic [7:0] VER_LIMIT = 8'hff;
  localparam logic [7:0] SZ_LIMIT  = 8'h80;
  localparam logic [6:0] SZ_MASK   = 7'h7f;

  localparam logic [3:0] HDR_LAST  = 4'd9;
  localparam logic [3:0] FID_END   = 4'd4;
  localparam logic [3:0] FSIZE_END = 4'd8;

  typedef enum logic [2:0] {
    PH_OUTSIDE   = 3'd0,
    PH_HEADER    = 3'd1,
    PH_FHDR      = 3'd2,
    PH_PAYLOAD   = 3'd3,
    PH_PADDING   = 3'd4,
    PH_MALFORMED = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    EV_HDR_BYTE       = 4'd0,
    EV_TAG_OK         = 4'd1,
    EV_NOT_TAG        = 4'd2,
    EV_FRAME_HDR_BYTE = 4'd3,
    EV_FRAME_HDR_DONE = 4'd4,
    EV_PAYLOAD        = 4'd5,
    EV_PADDING        = 4'd6,
    EV_OUTSIDE        = 4'd7,
    EV_MALFORMED      = 4'd8
  } event_t;

  typedef struct packed {
    phase_t       phase;
    logic [3:0]   hidx;
    logic [27:0]  tag_rem;
    logic [31:0]  frame_rem;
    logic [15:0]  version;
    logic [7:0]   tflags;
    logic [27:0]  tsize;
    logic [31:0]  fid;
    logic [31:0]  fsize;
    logic [15:0]  fflags;
  } state_t;

  typedef struct packed {
    event_t       ev;
    logic [15:0]  tag_version;
    logic [7:0]   tag_flags;
    logic [27:0]  tag_size;
    logic [31:0]  frame_id;
    logic [31:0]  frame_size;
    logic [15:0]  frame_flags;
    logic [7:0]   payload_byte;
    logic         tag_end;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:     PH_OUTSIDE,
    hidx:      4'd0,
    tag_rem:   28'd0,
    frame_rem: 32'd0,
    version:   16'd0,
    tflags:    8'd0,
    tsize:     28'd0,
    fid:       32'd0,
    fsize:     32'd0,
    fflags:    16'd0
  };

endpackage

// File: rtl/id3_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3_in_if
// Byte request channel into the parser.
// ----------------------------------------------------------------------------
interface id3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

// File: rtl/id3_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3_out_if
// Event request channel out of the parser.
// ----------------------------------------------------------------------------
interface id3_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [15:0] tag_version;
  logic [7:0]  tag_flags;
  logic [27:0] tag_size;
  logic [31:0] frame_id;
  logic [31:0] frame_size;
  logic [15:0] frame_flags;
  logic [7:0]  payload_byte;
  logic        tag_end;

  modport source (
    output valid, output event_res, output tag_version, output tag_flags,
    output tag_size, output frame_id, output frame_size, output frame_flags,
    output payload_byte, output tag_end, input ready
  );
  modport sink (
    input valid, input event_res, input tag_version, input tag_flags,
    input tag_size, input frame_id, input frame_size, input frame_flags,
    input payload_byte, input tag_end, output ready
  );
endinterface

// File: rtl/id3_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3_step
// Next-state and event logic for one file byte.
// ----------------------------------------------------------------------------
module id3_step (
  input  id3_pkg::state_t  cur,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  output id3_pkg::state_t  nxt,
  output id3_pkg::result_t res
);

  function automatic logic header_byte_ok(input logic [3:0] idx, input logic [7:0] b);
    logic ok;
    case (idx)
      4'd0:       ok = (b == id3_pkg::CHAR_I);
      4'd1:       ok = (b == id3_pkg::CHAR_D);
      4'd2:       ok = (b == id3_pkg::CHAR_3);
      4'd3, 4'd4: ok = (b < id3_pkg::VER_LIMIT);
      4'd5:       ok = 1'b1;
      default:    ok = (b < id3_pkg::SZ_LIMIT);
    endcase
    return ok;
  endfunction

  always_comb begin
    id3_pkg::state_t s;
    id3_pkg::event_t ev;
    logic [7:0]      pay;
    logic            tend;
    logic            zero_fields;
    logic [27:0]     rem;
    logic            last;
    logic [31:0]     frem;

    s           = cur;
    ev          = id3_pkg::EV_OUTSIDE;
    pay         = 8'd0;
    tend        = 1'b0;
    zero_fields = 1'b0;
    rem         = 28'd0;
    last        = 1'b0;
    frem        = 32'd0;

    if (first_byte) begin
      s.phase = id3_pkg::PH_HEADER;
      s.hidx  = 4'd0;
    end

    unique case (s.phase)
      id3_pkg::PH_OUTSIDE: begin
        zero_fields = 1'b1;
      end
      id3_pkg::PH_HEADER: begin
        if (s.hidx == 4'd0) begin
          s           = id3_pkg::STATE_RESET;
          s.phase     = id3_pkg::PH_HEADER;
        end
        if (s.hidx > id3_pkg::HDR_LAST || !header_byte_ok(s.hidx, data_byte)) begin
          ev          = id3_pkg::EV_NOT_TAG;
          zero_fields = 1'b1;
          s           = id3_pkg::STATE_RESET;
        end else begin
          if (s.hidx == 4'd3) begin
            s.version = {data_byte, 8'd0};
          end else if (s.hidx == 4'd4) begin
            s.version = {s.version[15:8], data_byte};
          end else if (s.hidx == 4'd5) begin
            s.tflags = data_byte;
          end else if (s.hidx >= 4'd6) begin
            s.tsize = {s.tsize[20:0], data_byte[6:0] & id3_pkg::SZ_MASK};
          end
          if (s.hidx < id3_pkg::HDR_LAST) begin
            ev     = id3_pkg::EV_HDR_BYTE;
            s.hidx = s.hidx + 4'd1;
          end else begin
            ev        = id3_pkg::EV_TAG_OK;
            s.hidx    = 4'd0;
            s.tag_rem = s.tsize;
            if (s.tsize == 28'd0) begin
              tend    = 1'b1;
              s.phase = id3_pkg::PH_HEADER;
            end else begin
              s.phase = id3_pkg::PH_FHDR;
            end
          end
        end
      end
      default: begin
        rem       = (s.tag_rem == 28'd0) ? 28'd0 : s.tag_rem - 28'd1;
        last      = (rem == 28'd0);
        s.tag_rem = rem;

        if (s.phase == id3_pkg::PH_FHDR) begin
          if (s.hidx == 4'd0 && data_byte == 8'd0) begin
            ev      = id3_pkg::EV_PADDING;
            s.fid   = 32'd0;
            s.fsize = 32'd0;
            s.fflags = 16'd0;
            s.phase = id3_pkg::PH_PADDING;
          end else begin
            if (s.hidx == 4'd0) begin
              s.fid    = 32'd0;
              s.fsize  = 32'd0;
              s.fflags = 16'd0;
            end
            if (s.hidx < id3_pkg::FID_END) begin
              s.fid = {s.fid[23:0], data_byte};
            end else if (s.hidx < id3_pkg::FSIZE_END) begin
              s.fsize = {s.fsize[23:0], data_byte};
            end else begin
              s.fflags = {s.fflags[7:0], data_byte};
            end
            if (s.hidx < id3_pkg::HDR_LAST) begin
              ev     = last ? id3_pkg::EV_MALFORMED : id3_pkg::EV_FRAME_HDR_BYTE;
              s.hidx = s.hidx + 4'd1;
            end else begin
              s.hidx = 4'd0;
              if (s.fsize > {4'd0, rem}) begin
                ev      = id3_pkg::EV_MALFORMED;
                s.phase = id3_pkg::PH_MALFORMED;
              end else begin
                ev          = id3_pkg::EV_FRAME_HDR_DONE;
                s.frame_rem = s.fsize;
                s.phase     = (s.fsize == 32'd0) ? id3_pkg::PH_FHDR : id3_pkg::PH_PAYLOAD;
              end
            end
          end
        end else if (s.phase == id3_pkg::PH_PAYLOAD) begin
          ev   = id3_pkg::EV_PAYLOAD;
          pay  = data_byte;
          frem = (s.frame_rem == 32'd0) ? 32'd0 : s.frame_rem - 32'd1;
          s.frame_rem = frem;
          if (frem == 32'd0) begin
            s.phase = id3_pkg::PH_FHDR;
            s.hidx  = 4'd0;
          end
        end else if (s.phase == id3_pkg::PH_PADDING) begin
          ev = id3_pkg::EV_PADDING;
        end else begin
          ev = id3_pkg::EV_MALFORMED;
        end

        if (last) begin
          tend        = 1'b1;
          s.phase     = id3_pkg::PH_HEADER;
          s.hidx      = 4'd0;
          s.frame_rem = 32'd0;
        end
      end
    endcase

    nxt              = s;
    res.ev           = ev;
    res.payload_byte = pay;
    res.tag_end      = tend;
    if (zero_fields) begin
      res.tag_version = 16'd0;
      res.tag_flags   = 8'd0;
      res.tag_size    = 28'd0;
      res.frame_id    = 32'd0;
      res.frame_size  = 32'd0;
      res.frame_flags = 16'd0;
    end else begin
      res.tag_version = s.version;
      res.tag_flags   = s.tflags;
      res.tag_size    = s.tsize;
      res.frame_id    = s.fid;
      res.frame_size  = s.fsize;
      res.frame_flags = s.fflags;
    end
  end

endmodule

// File: rtl/id3v2_tag_stream_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_tag_stream_parser_top
// ID3v2 tag stream parser: one event per file byte.
//
// The bytes channel carries file bytes in order; first_byte marks the first
// byte of a new file and restarts the parser in any phase. The events
// channel returns exactly one event per byte, in order, with the current tag
// and frame header fields.
// Throughput: one byte per cycle while events are taken. A byte is held
// in an input register, the per-byte step logic runs between that register
// and the parser state and event registers, so each byte passes through the
// input register and then the event register before its event is offered.
// When the receiver stalls, the event register holds; the input register
// still takes one more byte, and bytes.ready drops only while both are full.
// Reset (synchronous, active high) empties both registers and puts the
// parser outside any tag, waiting for a first byte.
// ----------------------------------------------------------------------------
module id3v2_tag_stream_parser_top (
  input  logic             clk,
  input  logic             rst,
  id3_in_if.sink           bytes,
  id3_out_if.source        events
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_first;
  logic             out_valid;
  id3_pkg::result_t out_res;
  id3_pkg::state_t  state;
  id3_pkg::state_t  state_next;
  id3_pkg::result_t res_next;
  logic             accept;
  logic             advance;

  assign advance     = s1_valid && (!out_valid || events.ready);
  assign bytes.ready = !s1_valid || advance;
  assign accept      = bytes.valid && bytes.ready;

  id3_step u_step (
    .cur        (state),
    .data_byte  (s1_byte),
    .first_byte (s1_first),
    .nxt        (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte  <= bytes.data_byte;
      s1_first <= bytes.first_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= id3_pkg::STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign events.valid        = out_valid;
  assign events.event_res    = 4'(out_res.ev);
  assign events.tag_version  = out_res.tag_version;
  assign events.tag_flags    = out_res.tag_flags;
  assign events.tag_size     = out_res.tag_size;
  assign events.frame_id     = out_res.frame_id;
  assign events.frame_size   = out_res.frame_size;
  assign events.frame_flags  = out_res.frame_flags;
  assign events.payload_byte = out_res.payload_byte;
  assign events.tag_end      = out_res.tag_end;

endmodule

// File: rtl/id3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3_checker
// Port-level checks on the parser, bound to the top level.
// ----------------------------------------------------------------------------
module id3_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] event_res,
  input logic [7:0] payload_byte,
  input logic       tag_end
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res)
      && $stable(payload_byte) && $stable(tag_end))
    else $error("event changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("event offered after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("byte refused with no event pending");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != 4'(id3_pkg::EV_PAYLOAD) |-> payload_byte == 8'd0)
    else $error("payload byte on non-payload event");

  a_no_tag_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == 4'(id3_pkg::EV_HDR_BYTE)
      || event_res == 4'(id3_pkg::EV_FRAME_HDR_BYTE)
      || event_res == 4'(id3_pkg::EV_OUTSIDE)
      || event_res == 4'(id3_pkg::EV_NOT_TAG)) |-> !tag_end)
    else $error("tag end on an event that cannot end a tag");

endmodule

bind id3v2_tag_stream_parser_top id3_checker u_id3_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (bytes.ready),
  .out_valid    (events.valid),
  .out_ready    (events.ready),
  .event_res    (events.event_res),
  .payload_byte (events.payload_byte),
  .tag_end      (events.tag_end)
);
